// File: sv/rar_pkg.sv
// Shared widths and operation codes for the fraction arithmetic block.
package rar_pkg;

  // Width of each operand, and of the cross-product sums and their magnitudes.
  localparam int OPW   = 16;
  localparam int PW    = 2 * OPW;
  localparam int MW    = 2 * OPW + 1;
  localparam int CMD_W = 2;
  localparam int CNT_W = $clog2(MW);

  // Operation codes carried on the command field.
  typedef enum logic [CMD_W-1:0] {
    CMD_MUL = 2'd0,
    CMD_ADD = 2'd1,
    CMD_DIV = 2'd2,
    CMD_SUB = 2'd3
  } cmd_e;

endpackage

// File: sv/rational_arith_reduce.sv
// Fraction arithmetic with reduction by the greatest common divisor.
//
// Channel  Ports                                         Direction  Handshake
// request  cmd_i, a_num_i, a_den_i, b_num_i, b_den_i     in         start && !busy
// result   res_num_o, res_den_o, zero_error_o            out        valid_o, one cycle
//
// A request whose combined values are both zero ends at the zero check. Any
// other request runs four products on the shared 16x16 multiplier, a combine
// and zero check, a binary GCD loop of one subtract or shift a cycle with each
// common factor of two removed and later restored, then two restoring divisions
// of 33 steps each on one shared subtractor. Reset clears the sequencer and the
// result strobe. The result is shown for exactly one cycle and the receiver
// cannot stall it.
module rational_arith_reduce (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [rar_pkg::CMD_W-1:0]     cmd_i,
  input  logic signed [rar_pkg::OPW-1:0] a_num_i,
  input  logic signed [rar_pkg::OPW-1:0] a_den_i,
  input  logic signed [rar_pkg::OPW-1:0] b_num_i,
  input  logic signed [rar_pkg::OPW-1:0] b_den_i,
  output logic                          valid_o,
  output logic signed [rar_pkg::MW-1:0] res_num_o,
  output logic signed [rar_pkg::MW-1:0] res_den_o,
  output logic                          zero_error_o
);
  import rar_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_COMB,
    S_MAG,
    S_TWO,
    S_ODD,
    S_REST,
    S_DIV
  } state_e;

  state_e                 state_q;
  logic [CMD_W-1:0]       cmd_q;
  logic signed [OPW-1:0]  an_q, ad_q, bn_q, bd_q;
  logic signed [PW-1:0]   p_nn_q, p_dd_q, p_nd_q, p_dn_q;
  logic signed [MW-1:0]   num_q, den_q;
  logic [MW-1:0]          u_q, v_q;
  logic [CNT_W-1:0]       k_q;
  logic [CNT_W-1:0]       cnt_q;
  logic [1:0]             mul_idx_q;
  logic                   sel_q;
  logic [MW-1:0]          rem_q, quo_q;
  logic                   valid_q, zero_err_q;
  logic signed [MW-1:0]   res_num_q, res_den_q;

  // Shared multiplier: operands chosen by the product index.
  logic signed [OPW-1:0] mul_a, mul_b;
  logic signed [PW-1:0]  mul_p;

  always_comb begin
    case (mul_idx_q)
      2'd0: begin
        mul_a = an_q;
        mul_b = bn_q;
      end
      2'd1: begin
        mul_a = ad_q;
        mul_b = bd_q;
      end
      2'd2: begin
        mul_a = an_q;
        mul_b = bd_q;
      end
      default: begin
        mul_a = ad_q;
        mul_b = bn_q;
      end
    endcase
    mul_p = PW'(mul_a) * PW'(mul_b);
  end

  // Sign-extended products for the combine step.
  logic signed [MW-1:0] x_nn, x_dd, x_nd, x_dn;
  assign x_nn = {{(MW-PW){p_nn_q[PW-1]}}, p_nn_q};
  assign x_dd = {{(MW-PW){p_dd_q[PW-1]}}, p_dd_q};
  assign x_nd = {{(MW-PW){p_nd_q[PW-1]}}, p_nd_q};
  assign x_dn = {{(MW-PW){p_dn_q[PW-1]}}, p_dn_q};

  // Numerator and denominator before reduction.
  logic signed [MW-1:0] num_d, den_d;
  always_comb begin
    case (cmd_e'(cmd_q))
      CMD_MUL: begin
        num_d = x_nn;
        den_d = x_dd;
      end
      CMD_ADD: begin
        num_d = x_nd + x_dn;
        den_d = x_dd;
      end
      CMD_DIV: begin
        num_d = x_nd;
        den_d = x_dn;
      end
      default: begin
        num_d = x_nd - x_dn;
        den_d = x_dd;
      end
    endcase
  end

  // Magnitudes of the unreduced values.
  logic [MW-1:0] num_mag, den_mag;
  assign num_mag = num_q[MW-1] ? MW'(-num_q) : MW'(num_q);
  assign den_mag = den_q[MW-1] ? MW'(-den_q) : MW'(den_q);

  // GCD subtract: larger odd value minus the smaller one.
  logic          u_ge_v;
  logic [MW-1:0] gcd_diff;
  assign u_ge_v   = (u_q >= v_q);
  assign gcd_diff = u_ge_v ? (u_q - v_q) : (v_q - u_q);

  // Restoring division step against the divisor held in v_q.
  logic [MW:0]   trial;
  logic          q_bit;
  logic [MW-1:0] rem_next, quo_next;
  logic [MW-1:0] quo_signed;
  logic          div_neg;
  assign trial    = {rem_q, quo_q[MW-1]};
  assign q_bit    = (trial >= {1'b0, v_q});
  assign rem_next = q_bit ? MW'(trial - {1'b0, v_q}) : trial[MW-1:0];
  assign quo_next = {quo_q[MW-2:0], q_bit};
  assign div_neg  = sel_q ? den_q[MW-1] : num_q[MW-1];
  assign quo_signed = div_neg ? MW'(-quo_next) : quo_next;

  // Sequencer, datapath registers and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      valid_q    <= 1'b0;
      zero_err_q <= 1'b0;
      mul_idx_q  <= 2'd0;
      cnt_q      <= '0;
      k_q        <= '0;
      sel_q      <= 1'b0;
    end else begin
      case (state_q)
        // The strobe is only ever raised on the way back here, so it drops now.
        S_IDLE: begin
          valid_q <= 1'b0;
          if (start) begin
            cmd_q     <= cmd_i;
            an_q      <= a_num_i;
            ad_q      <= a_den_i;
            bn_q      <= b_num_i;
            bd_q      <= b_den_i;
            mul_idx_q <= 2'd0;
            state_q   <= S_MUL;
          end
        end
        S_MUL: begin
          case (mul_idx_q)
            2'd0:    p_nn_q <= mul_p;
            2'd1:    p_dd_q <= mul_p;
            2'd2:    p_nd_q <= mul_p;
            default: p_dn_q <= mul_p;
          endcase
          mul_idx_q <= mul_idx_q + 2'd1;
          if (mul_idx_q == 2'd3) begin
            state_q <= S_COMB;
          end
        end
        S_COMB: begin
          num_q   <= num_d;
          den_q   <= den_d;
          state_q <= S_MAG;
        end
        S_MAG: begin
          if (num_q == '0 && den_q == '0) begin
            res_num_q  <= '0;
            res_den_q  <= '0;
            zero_err_q <= 1'b1;
            valid_q    <= 1'b1;
            state_q    <= S_IDLE;
          end else begin
            u_q     <= num_mag;
            v_q     <= den_mag;
            k_q     <= '0;
            state_q <= S_TWO;
          end
        end
        // Strip common factors of two; a zero value leaves the other as divisor.
        S_TWO: begin
          if (u_q == '0) begin
            state_q <= S_REST;
          end else if (v_q == '0) begin
            v_q     <= u_q;
            state_q <= S_REST;
          end else if (!u_q[0] && !v_q[0]) begin
            u_q <= u_q >> 1;
            v_q <= v_q >> 1;
            k_q <= k_q + 1'b1;
          end else begin
            state_q <= S_ODD;
          end
        end
        // Binary GCD on values that share no factor of two.
        S_ODD: begin
          if (u_q == '0) begin
            state_q <= S_REST;
          end else if (!u_q[0]) begin
            u_q <= u_q >> 1;
          end else if (!v_q[0]) begin
            v_q <= v_q >> 1;
          end else if (u_ge_v) begin
            u_q <= gcd_diff >> 1;
          end else begin
            v_q <= gcd_diff >> 1;
          end
        end
        // Put the common factors of two back, then start on the numerator.
        S_REST: begin
          if (k_q == '0) begin
            rem_q   <= '0;
            quo_q   <= num_mag;
            cnt_q   <= '0;
            sel_q   <= 1'b0;
            state_q <= S_DIV;
          end else begin
            v_q <= v_q << 1;
            k_q <= k_q - 1'b1;
          end
        end
        // One quotient bit a cycle; numerator first, then denominator.
        S_DIV: begin
          if (cnt_q == CNT_W'(MW - 1)) begin
            cnt_q <= '0;
            rem_q <= '0;
            if (!sel_q) begin
              res_num_q <= quo_signed;
              quo_q     <= den_mag;
              sel_q     <= 1'b1;
            end else begin
              res_den_q  <= quo_signed;
              zero_err_q <= 1'b0;
              valid_q    <= 1'b1;
              state_q    <= S_IDLE;
            end
          end else begin
            rem_q <= rem_next;
            quo_q <= quo_next;
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: begin
          valid_q <= 1'b0;
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy         = (state_q != S_IDLE);
  assign valid_o      = valid_q;
  assign res_num_o    = res_num_q;
  assign res_den_o    = res_den_q;
  assign zero_error_o = zero_err_q;

endmodule
